@@ hdl/i2c_mbe_pkg.sv @@
// ----------------------------------------------------------------------------
// i2c_mbe_pkg
// Shared types and constants of the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2c_mbe_pkg;

    // Command codes
    localparam logic [2:0] OP_IDLE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    // Field widths
    localparam int unsigned CMD_W   = 3;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned COUNT_W = 4;

    // Bits per byte transfer on the bus
    localparam logic [COUNT_W-1:0] BITS_PER_BYTE = 4'd8;

    // Bus engine state
    typedef struct packed {
        logic [CMD_W-1:0]   operation;
        logic [PHASE_W-1:0] phase;
        logic [COUNT_W-1:0] bit_count;
        logic [BYTE_W-1:0]  shift_reg;
        logic               ack_to_send;
        logic               ack_seen;
        logic               scl_level;
        logic               sda_level;
        logic [BYTE_W-1:0]  last_read;
    } engine_state_t;

    // One input item
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [BYTE_W-1:0] data_byte;
        logic              send_ack;
        logic              scl_sample;
        logic              sda_sample;
    } tick_item_t;

    localparam engine_state_t STATE_RESET = '{
        operation:   OP_IDLE,
        phase:       '0,
        bit_count:   '0,
        shift_reg:   '0,
        ack_to_send: 1'b0,
        ack_seen:    1'b0,
        scl_level:   1'b1,
        sda_level:   1'b1,
        last_read:   '0
    };

endpackage

@@ hdl/i2c_master_bit_engine.sv @@
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// Bit-banged I2C master: one pin phase of start, stop, write or read per tick.
// ----------------------------------------------------------------------------
//  Channel | Dir | Fields (lowest bit first)
//  --------+-----+----------------------------------------------------------
//  s_      | in  | tuser: command; tdata: data_byte, send_ack, scl_sample,
//          |     |        sda_sample
//  m_      | out | tdata: scl_drive, sda_drive, busy_res, done_res,
//          |     |        read_byte, ack_bit
//
// One result per tick; a tick is taken every cycle while the result is not stalled,
// via input and result registers. The single engine state register sets the rate.
// Reset (aresetn low, synchronous) releases both lines and returns to idle.
// A stalled result holds the engine; one tick waits in the input register.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // command
    input  logic [15:0] s_tdata,   // data_byte, send_ack, scl_sample, sda_sample, pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // scl_drive, sda_drive, busy_res, done_res,
                                   // read_byte, ack_bit, pad
);

    logic                       in_valid_reg;
    i2c_mbe_pkg::tick_item_t    item_reg;
    i2c_mbe_pkg::engine_state_t state_reg;
    i2c_mbe_pkg::engine_state_t state_next;
    logic                       done_next;
    logic                       out_valid_reg;
    logic [15:0]                out_data_reg;
    logic [15:0]                out_data_next;
    logic                       advance;

    // engine steps when a tick is held and the result slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= '{
                command:    s_tuser,
                data_byte:  s_tdata[7:0],
                send_ack:   s_tdata[8],
                scl_sample: s_tdata[9],
                sda_sample: s_tdata[10]
            };
        end
    end

    // phase logic
    i2c_mbe_step u_step (
        .state_cur (state_reg),
        .item      (item_reg),
        .state_nxt (state_next),
        .done      (done_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= i2c_mbe_pkg::STATE_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // result register
    assign out_data_next = {3'b000,
                            state_next.ack_seen,
                            state_next.last_read,
                            done_next,
                            (state_next.operation != i2c_mbe_pkg::OP_IDLE),
                            state_next.sda_level,
                            state_next.scl_level};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ hdl/i2c_mbe_step.sv @@
// ----------------------------------------------------------------------------
// i2c_mbe_step
// Next-state logic: one pin phase of the running command per tick.
// ----------------------------------------------------------------------------
module i2c_mbe_step (
    input  i2c_mbe_pkg::engine_state_t state_cur,
    input  i2c_mbe_pkg::tick_item_t    item,
    output i2c_mbe_pkg::engine_state_t state_nxt,
    output logic                       done
);

    i2c_mbe_pkg::engine_state_t st;
    logic [i2c_mbe_pkg::COUNT_W-1:0] cnt_inc;

    always_comb begin
        st      = state_cur;
        done    = 1'b0;
        cnt_inc = state_cur.bit_count + 1'b1;

        // command is taken only while idle
        if (st.operation == i2c_mbe_pkg::OP_IDLE) begin
            if (item.command inside {i2c_mbe_pkg::OP_START, i2c_mbe_pkg::OP_STOP,
                                     i2c_mbe_pkg::OP_WRITE, i2c_mbe_pkg::OP_READ}) begin
                st.operation = item.command;
                st.phase     = '0;
                st.bit_count = '0;
                if (item.command == i2c_mbe_pkg::OP_WRITE) begin
                    st.shift_reg = item.data_byte;
                end
                if (item.command == i2c_mbe_pkg::OP_READ) begin
                    st.ack_to_send = item.send_ack;
                end
            end
        end
        cnt_inc = st.bit_count + 1'b1;

        // run one phase
        case (st.operation)
            i2c_mbe_pkg::OP_START: begin
                case (st.phase)
                    3'd0: begin st.sda_level = 1'b1; st.phase = 3'd1; end
                    3'd1: begin st.scl_level = 1'b1; st.phase = 3'd2; end
                    3'd2: begin st.sda_level = 1'b0; st.phase = 3'd3; end
                    default: begin st.scl_level = 1'b0; done = 1'b1; end
                endcase
            end
            i2c_mbe_pkg::OP_STOP: begin
                case (st.phase)
                    3'd0: begin st.sda_level = 1'b0; st.phase = 3'd1; end
                    3'd1: begin st.scl_level = 1'b1; st.phase = 3'd2; end
                    default: begin st.sda_level = 1'b1; done = 1'b1; end
                endcase
            end
            i2c_mbe_pkg::OP_WRITE: begin
                case (st.phase)
                    3'd0: begin
                        st.sda_level = st.shift_reg[i2c_mbe_pkg::BYTE_W-1];
                        st.phase     = 3'd1;
                    end
                    3'd1: begin
                        st.scl_level = 1'b1;
                        st.shift_reg = {st.shift_reg[i2c_mbe_pkg::BYTE_W-2:0], 1'b0};
                        st.phase     = 3'd2;
                    end
                    3'd2: begin
                        st.scl_level = 1'b0;
                        st.bit_count = cnt_inc;
                        st.phase     = (cnt_inc >= i2c_mbe_pkg::BITS_PER_BYTE) ? 3'd3 : 3'd0;
                    end
                    3'd3: begin st.sda_level = 1'b1; st.phase = 3'd4; end
                    3'd4: begin st.scl_level = 1'b1; st.phase = 3'd5; end
                    default: begin
                        st.ack_seen  = item.sda_sample;
                        st.scl_level = 1'b0;
                        done         = 1'b1;
                    end
                endcase
            end
            i2c_mbe_pkg::OP_READ: begin
                case (st.phase)
                    3'd0: begin
                        st.sda_level = 1'b1;
                        st.shift_reg = '0;
                        st.phase     = 3'd1;
                    end
                    3'd1: begin st.scl_level = 1'b1; st.phase = 3'd2; end
                    3'd2: begin
                        // hold SCL released while the target stretches the clock
                        if (!item.scl_sample) begin
                            st.scl_level = 1'b1;
                        end else begin
                            st.shift_reg = {st.shift_reg[i2c_mbe_pkg::BYTE_W-2:0],
                                            item.sda_sample};
                            st.scl_level = 1'b0;
                            st.bit_count = cnt_inc;
                            st.phase     = (cnt_inc >= i2c_mbe_pkg::BITS_PER_BYTE) ?
                                           3'd3 : 3'd1;
                        end
                    end
                    3'd3: begin st.sda_level = ~st.ack_to_send; st.phase = 3'd4; end
                    3'd4: begin st.scl_level = 1'b1; st.phase = 3'd5; end
                    3'd5: begin st.scl_level = 1'b0; st.phase = 3'd6; end
                    default: begin
                        st.sda_level = 1'b1;
                        st.last_read = st.shift_reg;
                        done         = 1'b1;
                    end
                endcase
            end
            default: begin
                st.phase = st.phase;
            end
        endcase

        // back to idle on completion
        if (done) begin
            st.operation = i2c_mbe_pkg::OP_IDLE;
            st.phase     = '0;
            st.bit_count = '0;
        end
        state_nxt = st;
    end

endmodule
